// ===== rtl/fwrf_pkg.sv =====
// ----------------------------------------------------------------------------
// fwrf_pkg: shared types and constants of the fixed-window rate filter
// Entry record layout, configuration set, event and result types.
// ----------------------------------------------------------------------------
package fwrf_pkg;

  localparam int EntriesDefault = 1024;
  localparam int IdxInW         = 10;
  localparam int ModeW          = 2;
  localparam int TimeW          = 32;
  localparam int CountW         = 32;
  localparam int ActionW        = 4;
  localparam int StatusW        = 2;
  localparam int InTdataW       = 48;
  localparam int OutTdataW      = 40;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 32;

  // Per-entry filter state as stored in the table.
  typedef enum logic [1:0] {
    FS_NEW = 2'd0,
    FS_OFF = 2'd1,
    FS_ON  = 2'd2
  } fstate_e;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE = 2'd0,
    MODE_INC  = 2'd1,
    MODE_DEC  = 2'd2,
    MODE_CLR  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_UNDER = 2'd0,
    ST_CONT  = 2'd1,
    ST_START = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COUNT_LIMIT    = 3'd0,
    REG_PERIOD_SECONDS = 3'd1,
    REG_REVERT_TIMEOUT = 3'd2,
    REG_ACT_CODE       = 3'd3,
    REG_DROP_ADJUST    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    fstate_e            state;
    logic [CountW-1:0]  tally;
    logic [TimeW-1:0]   win_start;
    logic [TimeW-1:0]   act_time;
  } entry_rec_t;

  localparam int RecW = $bits(entry_rec_t);

  typedef struct packed {
    logic [CountW-1:0]  count_limit;
    logic [TimeW-1:0]   period_seconds;
    logic [TimeW-1:0]   revert_timeout;
    logic [ActionW-1:0] act_code;
    logic               drop_adjust;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic [TimeW-1:0]  now;
  } event_t;

  typedef struct packed {
    status_e            status;
    logic [ActionW-1:0] action;
    logic [CountW-1:0]  event_count;
  } result_t;

endpackage

// ===== rtl/fwrf_ram.sv =====
// ----------------------------------------------------------------------------
// fwrf_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module fwrf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fwrf_update.sv =====
// ----------------------------------------------------------------------------
// fwrf_update: entry update datapath
// Applies window expiry, the count operation and the revert check to the
// record read from the table, registers it, then decides the action and
// builds the record to write back together with the result.
// ----------------------------------------------------------------------------
module fwrf_update import fwrf_pkg::*; #(
  parameter int IdxW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            s1_valid_i,
  input  logic [IdxW-1:0] s1_idx_i,
  input  event_t          s1_ev_i,
  input  entry_rec_t      rec_i,
  input  cfg_t            cfg_i,
  output logic            wr_valid_o,
  output logic [IdxW-1:0] wr_idx_o,
  output entry_rec_t      wr_rec_o,
  output result_t         res_o
);

  logic [TimeW-1:0]  ws_d;
  logic [CountW-1:0] tally_d;
  logic              still_on_d;

  logic              s2_valid_q;
  logic [IdxW-1:0]   s2_idx_q;
  logic [TimeW-1:0]  s2_now_q;
  logic [TimeW-1:0]  s2_ws_q;
  logic [CountW-1:0] s2_tally_q;
  logic [TimeW-1:0]  s2_act_q;
  logic              s2_on_q;

  logic              over;
  status_e           status;
  fstate_e           state_new;
  logic [TimeW-1:0]  act_new;
  logic [CountW-1:0] count_new;

  // First half: window expiry, count operation, revert check.
  always_comb begin
    ws_d    = (rec_i.state == FS_NEW) ? s1_ev_i.now : rec_i.win_start;
    tally_d = rec_i.tally;
    if (cfg_i.period_seconds != '0 &&
        TimeW'(s1_ev_i.now - ws_d) >= cfg_i.period_seconds) begin
      ws_d    = s1_ev_i.now;
      tally_d = '0;
    end
    case (s1_ev_i.mode)
      MODE_INC: begin
        if (tally_d != '1) begin
          tally_d = tally_d + CountW'(1);
        end
      end
      MODE_DEC: begin
        if (cfg_i.period_seconds == '0 && tally_d != '0) begin
          tally_d = tally_d - CountW'(1);
        end
      end
      MODE_CLR: begin
        tally_d = '0;
      end
      default: begin
      end
    endcase
    still_on_d = (rec_i.state == FS_ON) &&
                 !(cfg_i.revert_timeout != '0 &&
                   TimeW'(s1_ev_i.now - rec_i.act_time) >= cfg_i.revert_timeout);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance_i) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && s1_valid_i) begin
      s2_idx_q   <= s1_idx_i;
      s2_now_q   <= s1_ev_i.now;
      s2_ws_q    <= ws_d;
      s2_tally_q <= tally_d;
      s2_act_q   <= rec_i.act_time;
      s2_on_q    <= still_on_d;
    end
  end

  // Second half: limit compare, action decision and the drop fix.
  always_comb begin
    over = s2_tally_q > cfg_i.count_limit;
    if (s2_on_q) begin
      status    = ST_CONT;
      state_new = FS_ON;
      act_new   = s2_act_q;
    end else if (over) begin
      status    = ST_START;
      state_new = FS_ON;
      act_new   = s2_now_q;
    end else begin
      status    = ST_UNDER;
      state_new = FS_OFF;
      act_new   = s2_act_q;
    end
    // The compare above guarantees a nonzero tally here.
    if (cfg_i.period_seconds == '0 && over && cfg_i.drop_adjust) begin
      count_new = s2_tally_q - CountW'(1);
    end else begin
      count_new = s2_tally_q;
    end
  end

  assign wr_valid_o         = s2_valid_q;
  assign wr_idx_o           = s2_idx_q;
  assign wr_rec_o.state     = state_new;
  assign wr_rec_o.tally     = count_new;
  assign wr_rec_o.win_start = s2_ws_q;
  assign wr_rec_o.act_time  = act_new;

  assign res_o.status      = status;
  assign res_o.action      = (status != ST_UNDER) ? cfg_i.act_code : '0;
  assign res_o.event_count = count_new;

endmodule

// ===== rtl/fixed_window_rate_filter.sv =====
// Reset: registers take their reset values and a clearing pass marks every
// table entry new before the first request is accepted. Requests pass the
// first stage, update and output registers. Throughput: one request per cycle
// barring output stalls; a request for the same entry as the one before it
// waits until that one leaves the first stage, since the table read-modify-
// write loop (read, update, write back) forwards only the registered write.
// ----------------------------------------------------------------------------
// fixed_window_rate_filter: per-entry fixed-window event rate filter
// Counts events per tracking entry in a table memory and reports when an
// entry goes over its limit, with window expiry and timed revert.
// ----------------------------------------------------------------------------
module fixed_window_rate_filter import fwrf_pkg::*; #(
  parameter int ENTRIES = EntriesDefault,
  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // s_axis_tdata_i: entry_index [9:0], mode [11:10], now [43:12], zero fill
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // m_axis_tdata_o: status [1:0], action [5:2], event_count [37:6], zero fill
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t              cfg_q;
  logic              init_busy_q;
  logic [IdxW-1:0]   init_cnt_q;

  logic [IdxInW-1:0] in_rem;
  logic [IdxW-1:0]   in_idx;
  event_t            in_ev;
  logic              advance;
  logic              accept;

  logic              s1_valid_q;
  logic [IdxW-1:0]   s1_idx_q;
  event_t            s1_ev_q;

  logic              wb_valid_q;
  logic [IdxW-1:0]   wb_idx_q;
  entry_rec_t        wb_rec_q;

  entry_rec_t        ram_rdata;
  entry_rec_t        rec_s1;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  entry_rec_t        ram_wdata;
  entry_rec_t        init_rec;

  logic              wr_valid;
  logic [IdxW-1:0]   wr_idx;
  entry_rec_t        wr_rec;
  result_t           res;

  logic              out_valid_q;
  result_t           out_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count_limit    <= CountW'(1);
      cfg_q.period_seconds <= '0;
      cfg_q.revert_timeout <= '0;
      cfg_q.act_code       <= '0;
      cfg_q.drop_adjust    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COUNT_LIMIT:    cfg_q.count_limit    <= cfg_data_i[CountW-1:0];
        REG_PERIOD_SECONDS: cfg_q.period_seconds <= cfg_data_i[TimeW-1:0];
        REG_REVERT_TIMEOUT: cfg_q.revert_timeout <= cfg_data_i[TimeW-1:0];
        REG_ACT_CODE:       cfg_q.act_code       <= cfg_data_i[ActionW-1:0];
        REG_DROP_ADJUST:    cfg_q.drop_adjust    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Clearing pass over the table after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_busy_q <= 1'b1;
      init_cnt_q  <= '0;
    end else if (init_busy_q) begin
      init_cnt_q <= init_cnt_q + IdxW'(1);
      if (init_cnt_q == IdxW'(ENTRIES - 1)) begin
        init_busy_q <= 1'b0;
      end
    end
  end

  // Entry index modulo ENTRIES by restoring subtraction of shifted constants.
  always_comb begin
    in_rem = s_axis_tdata_i[IdxInW-1:0];
    for (int k = IdxInW - 1; k >= 0; k--) begin
      if (32'(in_rem) >= (32'(ENTRIES) << k)) begin
        in_rem = in_rem - IdxInW'(32'(ENTRIES) << k);
      end
    end
  end

  assign in_idx      = IdxW'(in_rem);
  assign in_ev.mode  = mode_e'(s_axis_tdata_i[IdxInW+ModeW-1:IdxInW]);
  assign in_ev.now   = s_axis_tdata_i[IdxInW+ModeW+TimeW-1:IdxInW+ModeW];

  // The whole pipeline moves together whenever the output register can take
  // a result. A request waits while the first stage holds its entry, so that
  // its read sees the write-back through the forwarding register.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance && !init_busy_q && !(s1_valid_q && s1_idx_q == in_idx);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
      wb_valid_q <= wr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q <= in_idx;
      s1_ev_q  <= in_ev;
    end
    if (advance && wr_valid) begin
      wb_idx_q <= wr_idx;
      wb_rec_q <= wr_rec;
    end
  end

  assign rec_s1 = (wb_valid_q && wb_idx_q == s1_idx_q) ? wb_rec_q : ram_rdata;

  always_comb begin
    init_rec           = '0;
    init_rec.state     = FS_NEW;
  end

  assign ram_we    = init_busy_q || (advance && wr_valid);
  assign ram_waddr = init_busy_q ? init_cnt_q : wr_idx;
  assign ram_wdata = init_busy_q ? init_rec : wr_rec;

  fwrf_ram #(
    .Width (RecW),
    .Depth (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  fwrf_update #(
    .IdxW (IdxW)
  ) u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .s1_valid_i (s1_valid_q),
    .s1_idx_i   (s1_idx_q),
    .s1_ev_i    (s1_ev_q),
    .rec_i      (rec_s1),
    .cfg_i      (cfg_q),
    .wr_valid_o (wr_valid),
    .wr_idx_o   (wr_idx),
    .wr_rec_o   (wr_rec),
    .res_o      (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= wr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && wr_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutTdataW - $bits(result_t))'(0),
                            out_q.event_count, out_q.action, out_q.status};

  // The clearing pass owns the write port: no request may be in flight.
  a_init_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy_q |-> !s1_valid_q && !wr_valid)
    else $error("request in flight during table clearing pass");

  // Two in-flight requests never name the same entry.
  a_no_same_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && wr_valid |-> s1_idx_q != wr_idx)
    else $error("same entry in both update stages");

  // A newly started action means the count went over the limit.
  a_start_over_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_START |-> out_q.event_count >= cfg_q.count_limit)
    else $error("action started below the count limit");

endmodule
